FILE: rtl/core/assert_macros.svh
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define QVR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Next-cycle implication, masked while reset is asserted.
`define QVR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

// Next-cycle implication that also holds through reset.
`define QVR_ASSERT_NEXT_RST(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed: reset behaviour");

`endif

FILE: rtl/core/qvr_pkg.sv
`timescale 1ns / 1ps
package qvr_pkg;

  localparam int FX_W    = 32;          // 16.16 word
  localparam int FX_FRAC = 16;          // fraction bits
  localparam int FX_PW   = 2 * FX_W;    // full product width

  typedef logic signed [FX_W-1:0]  fx_t;
  typedef logic signed [FX_PW-1:0] fx_prod_t;

endpackage

FILE: rtl/core/qvr_in_if.sv
`timescale 1ns / 1ps
interface qvr_in_if import qvr_pkg::*; ();
  logic valid;
  logic ready;
  fx_t  vec_x;
  fx_t  vec_y;
  fx_t  vec_z;
  fx_t  quat_x;
  fx_t  quat_y;
  fx_t  quat_z;
  fx_t  quat_w;

  modport source (
    output valid, vec_x, vec_y, vec_z, quat_x, quat_y, quat_z, quat_w,
    input  ready
  );
  modport sink (
    input  valid, vec_x, vec_y, vec_z, quat_x, quat_y, quat_z, quat_w,
    output ready
  );
endinterface

FILE: rtl/core/qvr_out_if.sv
`timescale 1ns / 1ps
interface qvr_out_if import qvr_pkg::*; ();
  logic valid;
  logic ready;
  fx_t  rot_x;
  fx_t  rot_y;
  fx_t  rot_z;

  modport source (
    output valid, rot_x, rot_y, rot_z,
    input  ready
  );
  modport sink (
    input  valid, rot_x, rot_y, rot_z,
    output ready
  );
endinterface

FILE: rtl/core/quaternion_vector_rotate.sv
`timescale 1ns / 1ps
// Quaternion vector rotation, signed 16.16 fixed point.
// in_ch  : one transaction carries a vector v and a quaternion (x, y, z, w).
// out_ch : one transaction per input transaction, the rotated vector
//          (w^2 - |b|^2) v + 2 (v.b) b + 2 w (b x v), b = (x, y, z).
// Every product is a 16.16 multiply (bits 47..16 of the 64-bit product),
// every sum wraps at 32 bits, nothing saturates or normalises.
// Pipeline: four register stages, each holding one rank of work:
//   1) 13 multiplies (squares, dot terms, cross terms, w*w)
//   2) sums: |b|^2, v.b, cross product, k = w^2 - |b|^2, doubling of v.b, w
//   3) 9 multiplies (v*k, b*2(v.b), (b x v)*2w)
//   4) three-term sums into the output register
// Flow: an accepted transaction passes the stage registers in order, and
// out_ch.valid rises once it sits in the output register. Throughput: one
// transaction per cycle, limited by nothing but the output handshake.
// Back-pressure: each stage holds while the one ahead is full and stalled;
// in_ch.ready drops only once every stage holds an item. Bubbles are
// squeezed out, so nothing is lost or repeated while out_ch.ready is low.
// Reset (rst_n low, synchronous) empties all stages; data is not cleared.
module quaternion_vector_rotate import qvr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  qvr_in_if.sink    in_ch,
  qvr_out_if.source out_ch
);

  localparam int NSTG = 4;
  localparam int NM1  = 13;
  localparam int NM3  = 9;

  // stage-1 product slots
  localparam int P_XX = 0;
  localparam int P_YY = 1;
  localparam int P_ZZ = 2;
  localparam int P_VX = 3;   // vx*bx
  localparam int P_VY = 4;   // vy*by
  localparam int P_VZ = 5;   // vz*bz
  localparam int P_C0A = 6;  // by*vz
  localparam int P_C0B = 7;  // bz*vy
  localparam int P_C1A = 8;  // bz*vx
  localparam int P_C1B = 9;  // bx*vz
  localparam int P_C2A = 10; // bx*vy
  localparam int P_C2B = 11; // by*vx
  localparam int P_WW = 12;

  // ---------------- handshake chain ----------------
  logic [NSTG-1:0] vld_r;
  logic [NSTG:0]   rdy;

  assign rdy[NSTG] = out_ch.ready;
  for (genvar g = 0; g < NSTG; g++) begin : g_rdy
    assign rdy[g] = !vld_r[g] || rdy[g+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) vld_r[0] <= in_ch.valid;
      for (int i = 1; i < NSTG; i++) begin
        if (rdy[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  assign in_ch.ready  = rdy[0];
  assign out_ch.valid = vld_r[NSTG-1];

  // ---------------- stage 1: first rank of multiplies ----------------
  fx_t vin [3];
  fx_t bin [3];
  fx_t m1_a [NM1];
  fx_t m1_b [NM1];
  fx_t m1_p [NM1];

  assign vin[0] = in_ch.vec_x;
  assign vin[1] = in_ch.vec_y;
  assign vin[2] = in_ch.vec_z;
  assign bin[0] = in_ch.quat_x;
  assign bin[1] = in_ch.quat_y;
  assign bin[2] = in_ch.quat_z;

  always_comb begin
    m1_a[P_XX]  = bin[0];      m1_b[P_XX]  = bin[0];
    m1_a[P_YY]  = bin[1];      m1_b[P_YY]  = bin[1];
    m1_a[P_ZZ]  = bin[2];      m1_b[P_ZZ]  = bin[2];
    m1_a[P_VX]  = vin[0];      m1_b[P_VX]  = bin[0];
    m1_a[P_VY]  = vin[1];      m1_b[P_VY]  = bin[1];
    m1_a[P_VZ]  = vin[2];      m1_b[P_VZ]  = bin[2];
    m1_a[P_C0A] = bin[1];      m1_b[P_C0A] = vin[2];
    m1_a[P_C0B] = bin[2];      m1_b[P_C0B] = vin[1];
    m1_a[P_C1A] = bin[2];      m1_b[P_C1A] = vin[0];
    m1_a[P_C1B] = bin[0];      m1_b[P_C1B] = vin[2];
    m1_a[P_C2A] = bin[0];      m1_b[P_C2A] = vin[1];
    m1_a[P_C2B] = bin[1];      m1_b[P_C2B] = vin[0];
    m1_a[P_WW]  = in_ch.quat_w; m1_b[P_WW] = in_ch.quat_w;
  end

  for (genvar g = 0; g < NM1; g++) begin : g_mul1
    qvr_fxmul u_mul (.a(m1_a[g]), .b(m1_b[g]), .p(m1_p[g]));
  end

  fx_t p1_r [NM1];
  fx_t v1_r [3];
  fx_t b1_r [3];
  fx_t w1_r;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      p1_r <= m1_p;
      v1_r <= vin;
      b1_r <= bin;
      w1_r <= in_ch.quat_w;
    end
  end

  // ---------------- stage 2: sums and doubling ----------------
  fx_t bsq_nxt;
  fx_t dot_nxt;
  fx_t c_nxt [3];
  fx_t k_nxt;
  fx_t s_nxt;
  fx_t t_nxt;

  always_comb begin
    bsq_nxt  = p1_r[P_XX] + p1_r[P_YY] + p1_r[P_ZZ];
    dot_nxt  = p1_r[P_VX] + p1_r[P_VY] + p1_r[P_VZ];
    c_nxt[0] = p1_r[P_C0A] - p1_r[P_C0B];
    c_nxt[1] = p1_r[P_C1A] - p1_r[P_C1B];
    c_nxt[2] = p1_r[P_C2A] - p1_r[P_C2B];
    k_nxt    = p1_r[P_WW] - bsq_nxt;
    // multiply by 2.0 in 16.16 is a wrapping left shift
    s_nxt    = {dot_nxt[FX_W-2:0], 1'b0};
    t_nxt    = {w1_r[FX_W-2:0], 1'b0};
  end

  fx_t v2_r [3];
  fx_t b2_r [3];
  fx_t c2_r [3];
  fx_t k2_r;
  fx_t s2_r;
  fx_t t2_r;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      v2_r <= v1_r;
      b2_r <= b1_r;
      c2_r <= c_nxt;
      k2_r <= k_nxt;
      s2_r <= s_nxt;
      t2_r <= t_nxt;
    end
  end

  // ---------------- stage 3: second rank of multiplies ----------------
  // slot 3*i+0: v_i*k, 3*i+1: b_i*s, 3*i+2: c_i*t
  fx_t m3_a [NM3];
  fx_t m3_b [NM3];
  fx_t m3_p [NM3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m3_a[3*i]   = v2_r[i]; m3_b[3*i]   = k2_r;
      m3_a[3*i+1] = b2_r[i]; m3_b[3*i+1] = s2_r;
      m3_a[3*i+2] = c2_r[i]; m3_b[3*i+2] = t2_r;
    end
  end

  for (genvar g = 0; g < NM3; g++) begin : g_mul3
    qvr_fxmul u_mul (.a(m3_a[g]), .b(m3_b[g]), .p(m3_p[g]));
  end

  fx_t p3_r [NM3];

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      p3_r <= m3_p;
    end
  end

  // ---------------- stage 4: final sums, output register ----------------
  fx_t rot_nxt [3];
  fx_t rot_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rot_nxt[i] = p3_r[3*i] + p3_r[3*i+1] + p3_r[3*i+2];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      rot_r <= rot_nxt;
    end
  end

  assign out_ch.rot_x = rot_r[0];
  assign out_ch.rot_y = rot_r[1];
  assign out_ch.rot_z = rot_r[2];

endmodule

FILE: rtl/core/qvr_fxmul.sv
`timescale 1ns / 1ps
// 16.16 signed multiply: bits 47..16 of the exact 64-bit product.
module qvr_fxmul import qvr_pkg::*; (
  input  fx_t a,
  input  fx_t b,
  output fx_t p
);

  fx_prod_t a_ext;
  fx_prod_t b_ext;
  fx_prod_t full;

  assign a_ext = {{(FX_PW-FX_W){a[FX_W-1]}}, a};
  assign b_ext = {{(FX_PW-FX_W){b[FX_W-1]}}, b};
  assign full  = a_ext * b_ext;
  assign p     = full[FX_FRAC+FX_W-1:FX_FRAC];

endmodule

FILE: rtl/core/qvr_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Port-level checks on the rotation pipeline.
module qvr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] rot_x,
  input logic [31:0] rot_y,
  input logic [31:0] rot_z
);

  // stalled result stays put
  `QVR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(rot_x) && $stable(rot_y) && $stable(rot_z))

  // reset empties the pipe
  `QVR_ASSERT_NEXT_RST(a_rst_empty, clk, !rst_n, !out_valid)

  // a free output means no stage can be blocking the input
  `QVR_ASSERT_IMP(a_ready_flow, clk, rst_n, out_ready, in_ready)

  // an accepted transaction reaches the output
  `QVR_ASSERT_IMP(a_latency, clk, rst_n, in_valid && in_ready, ##4 out_valid)

endmodule

bind quaternion_vector_rotate qvr_checker u_qvr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .rot_x     (out_ch.rot_x),
  .rot_y     (out_ch.rot_y),
  .rot_z     (out_ch.rot_z)
);

FILE: tb/tb_quaternion_vector_rotate.sv
`timescale 1ns / 1ps
// Testbench for quaternion_vector_rotate.
// Drives vector/quaternion transactions into in_ch and checks every rotated
// vector on out_ch against a bit-exact 16.16 prediction computed here. Both
// channels idle at random. One phase holds the output off for a long
// stretch so that the pipeline fills and stalls its input.
module tb_quaternion_vector_rotate;
  import qvr_pkg::*;

  localparam int unsigned CLK_HALF    = 4;       // 8 ns period
  localparam int unsigned RST_CYCLES  = 6;
  localparam int unsigned CYCLE_LIMIT = 300000;  // several times the slowest run
  localparam int unsigned SETTLE_CYC  = 16;      // margin beyond the pipeline depth
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned RANDOM_ITEMS = 560;

  // Handy 16.16 constants
  localparam fx_t FX_ZERO    = 32'sh0000_0000;
  localparam fx_t FX_ONE     = 32'sh0001_0000;
  localparam fx_t FX_TWO     = 32'sh0002_0000;
  localparam fx_t FX_NEG_ONE = 32'shFFFF_0000;
  localparam fx_t FX_HALF    = 32'sh0000_8000;
  localparam fx_t FX_COS45   = 32'sh0000_B505;   // ~0.7071
  localparam fx_t FX_MAX     = 32'sh7FFF_FFFF;
  localparam fx_t FX_MIN     = 32'sh8000_0000;
  localparam fx_t FX_LSB_NEG = 32'shFFFF_FFFF;

  typedef struct packed {
    fx_t vec_x;
    fx_t vec_y;
    fx_t vec_z;
    fx_t quat_x;
    fx_t quat_y;
    fx_t quat_z;
    fx_t quat_w;
  } rot_req_t;

  typedef struct packed {
    fx_t rot_x;
    fx_t rot_y;
    fx_t rot_z;
  } rot_res_t;

  logic clk;
  logic rst_n;

  qvr_in_if  in_ch ();
  qvr_out_if out_ch ();

  quaternion_vector_rotate i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Rotated vectors still owed by the block, oldest first
  rot_res_t    rotated_q[$];
  int unsigned mismatch_cnt;
  int unsigned cycle_cnt;

  // Idling controls, set by the test tasks
  bit          src_idle_en;
  bit          snk_idle_en;
  int unsigned snk_hold_cycles;   // long output hold-off, counted by the sink

  // ---------------------------------------------------------------------
  // Clock, cycle limit
  // ---------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  // 16.16 multiply: full signed 64-bit product, bits 47..16 kept
  function automatic fx_t fx_mult(fx_t a, fx_t b);
    fx_prod_t p;
    p = fx_prod_t'(a) * fx_prod_t'(b);
    return p[FX_FRAC +: FX_W];
  endfunction

  // (w^2 - |b|^2) v + 2 (v.b) b + 2 w (b x v); sums wrap at 32 bits.
  // Truncation points follow the block's evaluation order exactly.
  function automatic rot_res_t rotate_vector(rot_req_t r);
    fx_t      v[3];
    fx_t      b[3];
    fx_t      c[3];
    fx_t      rot[3];
    fx_t      b_sq, v_dot_b, dot2, w2, k;
    rot_res_t res;
    v = '{r.vec_x, r.vec_y, r.vec_z};
    b = '{r.quat_x, r.quat_y, r.quat_z};
    b_sq    = fx_mult(b[0], b[0]) + fx_mult(b[1], b[1]) + fx_mult(b[2], b[2]);
    v_dot_b = fx_mult(v[0], b[0]) + fx_mult(v[1], b[1]) + fx_mult(v[2], b[2]);
    dot2    = fx_mult(v_dot_b, FX_TWO);
    w2      = fx_mult(r.quat_w, FX_TWO);
    c[0]    = fx_mult(b[1], v[2]) - fx_mult(b[2], v[1]);
    c[1]    = fx_mult(b[2], v[0]) - fx_mult(b[0], v[2]);
    c[2]    = fx_mult(b[0], v[1]) - fx_mult(b[1], v[0]);
    k       = fx_mult(r.quat_w, r.quat_w) - b_sq;
    for (int i = 0; i < 3; i++)
      rot[i] = fx_mult(v[i], k) + fx_mult(b[i], dot2) + fx_mult(c[i], w2);
    res.rot_x = rot[0];
    res.rot_y = rot[1];
    res.rot_z = rot[2];
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Monitors: accepted inputs push a prediction, results are checked
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    rot_req_t acc;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      acc.vec_x  = in_ch.vec_x;
      acc.vec_y  = in_ch.vec_y;
      acc.vec_z  = in_ch.vec_z;
      acc.quat_x = in_ch.quat_x;
      acc.quat_y = in_ch.quat_y;
      acc.quat_z = in_ch.quat_z;
      acc.quat_w = in_ch.quat_w;
      rotated_q.push_back(rotate_vector(acc));
    end
  end

  always @(posedge clk) begin
    rot_res_t want;
    fx_t      got[3];
    fx_t      exp_v[3];
    string    fname[3];
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (rotated_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("t=%0t unexpected result transaction (%h %h %h)", $realtime,
                   out_ch.rot_x, out_ch.rot_y, out_ch.rot_z);
      end else begin
        want  = rotated_q.pop_front();
        got   = '{out_ch.rot_x, out_ch.rot_y, out_ch.rot_z};
        exp_v = '{want.rot_x, want.rot_y, want.rot_z};
        fname = '{"rot_x", "rot_y", "rot_z"};
        for (int i = 0; i < 3; i++) begin
          if (got[i] !== exp_v[i]) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS)
              $display("t=%0t %s mismatch: expected %h actual %h", $realtime,
                       fname[i], exp_v[i], got[i]);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Idle lengths: mostly none or short, now and then long
  // ---------------------------------------------------------------------
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side: ready is driven at the falling edge. A requested hold-off
  // takes priority and is counted down here, one cycle per falling edge.
  initial begin
    int unsigned stall_left;
    int unsigned g;
    stall_left = 0;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (snk_hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        snk_hold_cycles--;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (snk_idle_en) begin
        g = pick_gap();
        out_ch.ready <= (g == 0);
        if (g > 0) stall_left = g - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------

  // Offers one transaction and returns once it has been accepted. With no
  // gap, valid stays high and the next call just replaces the payload.
  task automatic send_rotation(rot_req_t r);
    int unsigned g;
    @(negedge clk);
    in_ch.valid  <= 1'b1;
    in_ch.vec_x  <= r.vec_x;
    in_ch.vec_y  <= r.vec_y;
    in_ch.vec_z  <= r.vec_z;
    in_ch.quat_x <= r.quat_x;
    in_ch.quat_y <= r.quat_y;
    in_ch.quat_z <= r.quat_z;
    in_ch.quat_w <= r.quat_w;
    do @(posedge clk); while (!in_ch.ready);
    if (src_idle_en) begin
      g = pick_gap();
      if (g > 0) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
        repeat (g - 1) @(negedge clk);
      end
    end
  endtask

  // Sender pause: drop valid and wait until every result is back
  task automatic wait_results_done();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (rotated_q.size() != 0) @(negedge clk);
  endtask

  // Operand values: full range, realistic magnitudes, or corner words
  function automatic fx_t pick_corner();
    fx_t corners[10];
    corners = '{FX_ZERO, 32'sh1, FX_LSB_NEG, FX_ONE, FX_NEG_ONE, FX_MAX, FX_MIN,
                FX_COS45, FX_TWO, FX_HALF};
    return corners[$urandom_range(0, 9)];
  endfunction

  function automatic rot_req_t random_rotation();
    rot_req_t    r;
    int unsigned style;
    style = $urandom_range(0, 99);
    if (style < 30) begin
      // anything goes; exercises every bit and the wrapping
      r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end else if (style < 80) begin
      // vectors within +/-256.0, quaternion components within +/-1.0
      r.vec_x  = fx_t'($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
      r.vec_y  = fx_t'($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
      r.vec_z  = fx_t'($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
      r.quat_x = fx_t'($urandom_range(0, 32'h0002_0000)) - FX_ONE;
      r.quat_y = fx_t'($urandom_range(0, 32'h0002_0000)) - FX_ONE;
      r.quat_z = fx_t'($urandom_range(0, 32'h0002_0000)) - FX_ONE;
      r.quat_w = fx_t'($urandom_range(0, 32'h0002_0000)) - FX_ONE;
    end else begin
      r = {pick_corner(), pick_corner(), pick_corner(), pick_corner(),
           pick_corner(), pick_corner(), pick_corner()};
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Field extremes and the named corners: identity, exact rotations,
  // non-unit quaternions and products that overflow 16.16.
  task automatic test_directed_corners();
    rot_req_t dir[$];
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
    // vec_x, vec_y, vec_z, quat_x, quat_y, quat_z, quat_w
    dir.push_back('{FX_ZERO, FX_ZERO, FX_ZERO, FX_ZERO, FX_ZERO, FX_ZERO, FX_ZERO});
    // identity quaternion leaves v alone
    dir.push_back('{FX_ONE, FX_TWO, 32'shFFFD_0000, FX_ZERO, FX_ZERO, FX_ZERO, FX_ONE});
    // 90 deg about z
    dir.push_back('{FX_ONE, FX_ZERO, FX_ZERO, FX_ZERO, FX_ZERO, FX_COS45, FX_COS45});
    // 180 deg about x
    dir.push_back('{FX_ONE, FX_TWO, 32'sh0003_0000, FX_ONE, FX_ZERO, FX_ZERO, FX_ZERO});
    // non-unit: result scales with the squared norm
    dir.push_back('{FX_ONE, FX_ONE, FX_ONE, FX_ZERO, FX_ZERO, FX_ZERO, FX_TWO});
    dir.push_back('{FX_ONE, FX_NEG_ONE, FX_HALF, FX_ONE, FX_ONE, FX_ONE, FX_ONE});
    // extremes of every field
    dir.push_back('{FX_MAX, FX_MAX, FX_MAX, FX_MAX, FX_MAX, FX_MAX, FX_MAX});
    dir.push_back('{FX_MIN, FX_MIN, FX_MIN, FX_MIN, FX_MIN, FX_MIN, FX_MIN});
    dir.push_back('{FX_LSB_NEG, FX_LSB_NEG, FX_LSB_NEG, FX_LSB_NEG, FX_LSB_NEG,
                    FX_LSB_NEG, FX_LSB_NEG});
    dir.push_back('{32'sh1, 32'sh1, 32'sh1, 32'sh1, 32'sh1, 32'sh1, 32'sh1});
    dir.push_back('{FX_MAX, FX_MAX, FX_MAX, FX_MIN, FX_MIN, FX_MIN, FX_MIN});
    dir.push_back('{FX_MIN, FX_MIN, FX_MIN, FX_MAX, FX_MAX, FX_MAX, FX_MAX});
    // overflow: w^2 far beyond 16.16
    dir.push_back('{FX_ONE, FX_ONE, FX_ONE, FX_ZERO, FX_ZERO, FX_ZERO, FX_MAX});
    dir.push_back('{FX_ONE, FX_NEG_ONE, FX_ONE, FX_MAX, FX_MIN, FX_MAX, FX_ZERO});
    // alternating bit patterns
    dir.push_back('{32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555,
                    32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA});
    dir.push_back('{32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA,
                    32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555});
    // huge vector through the identity
    dir.push_back('{FX_MAX, FX_MIN, FX_LSB_NEG, FX_ZERO, FX_ZERO, FX_ZERO, FX_ONE});
    dir.push_back('{FX_HALF, FX_HALF, FX_HALF, FX_HALF, FX_HALF, FX_HALF, FX_HALF});
    foreach (dir[i]) send_rotation(dir[i]);
    wait_results_done();
  endtask

  // No idling on either side: one transaction every cycle
  task automatic test_back_to_back();
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    repeat (60) send_rotation(random_rotation());
    wait_results_done();
  endtask

  // Output held off while the input keeps offering: the stages fill, ready
  // on in_ch drops, and nothing may be lost or repeated on release.
  task automatic test_output_hold_off();
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    @(negedge clk);
    snk_hold_cycles = 150;
    repeat (40) send_rotation(random_rotation());
    wait_results_done();
    // second hold-off with random idling around it
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
    snk_hold_cycles = 90;
    repeat (30) send_rotation(random_rotation());
    wait_results_done();
  endtask

  // Bulk random traffic; idling switches off now and then for a stretch,
  // and the sender drains the block from time to time.
  task automatic test_random_traffic();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
      end else if (n % 100 == 30) begin
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
      end
      if (n % 160 == 159) wait_results_done();
      send_rotation(random_rotation());
    end
    wait_results_done();
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------
  initial begin
    rst_n           = 1'b0;
    mismatch_cnt    = 0;
    cycle_cnt       = 0;
    src_idle_en     = 1'b0;
    snk_idle_en     = 1'b0;
    snk_hold_cycles = 0;
    in_ch.valid     = 1'b0;
    in_ch.vec_x     = '0;
    in_ch.vec_y     = '0;
    in_ch.vec_z     = '0;
    in_ch.quat_x    = '0;
    in_ch.quat_y    = '0;
    in_ch.quat_z    = '0;
    in_ch.quat_w    = '0;
    repeat (RST_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    test_directed_corners();
    test_back_to_back();
    test_output_hold_off();
    test_random_traffic();

    // everything back; give the pipeline time to show any stray result
    repeat (SETTLE_CYC) @(posedge clk);
    if (mismatch_cnt == 0 && rotated_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: quaternion_vector_rotate.f
+incdir+rtl/core
rtl/core/qvr_pkg.sv
rtl/core/qvr_in_if.sv
rtl/core/qvr_out_if.sv
rtl/core/qvr_fxmul.sv
rtl/core/quaternion_vector_rotate.sv
rtl/core/qvr_checker.sv
tb/tb_quaternion_vector_rotate.sv
